[hdl/cl2n_pkg.sv]
// Package: widths, opcodes and types for the channel L2 normalize/scale unit.
`timescale 1ns / 1ps
package cl2n_pkg;
    localparam int CHANNELS_MAX = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int IDX_BITS     = 6;
    localparam int CNT_BITS     = 7;
    localparam int SUM_BITS     = 38;
    localparam int ROOT_BITS    = 19;
    localparam int PROD_BITS    = 32;

    localparam logic OP_LOAD_SCALE = 1'b0;
    localparam logic OP_DATA       = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQRT   = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_OUT    = 5'b10000
    } state_t;
endpackage

[hdl/channel_l2_normalize_scale_unit.sv]
// Top level: cross-channel L2 normalization with per-channel scale.
`timescale 1ns / 1ps
// Usage:
//  s_axis: one transfer per item. tdata fields from bit 0 up: opcode,
//  channel_index[5:0], scale_word[15:0], sample[15:0], zero padded to 40 bits;
//  tlast = last_in. Opcode 0 loads a scale word and gives no result,
//  opcode 1 stores a vector element and adds its square.
//  After the last element (tlast, or channel_count reached) the block
//  computes the floor square root bit by bit (one subtract/compare per
//  root bit), then per element a multiply, a restoring divider pass and
//  an output step, which waits for the output handshake. s_axis_tready
//  is low meanwhile.
//  m_axis: tdata = {result[15:0]}, tuser = out_channel[5:0], tlast =
//  last_out. A stalled receiver holds the result register; the
//  sequencer waits in its output state.
//  Reset clears the count, the sum and the scale table (via valid bits);
//  channel_count returns to 64. Write cfg_wr_en/cfg_wr_data only when idle.
module channel_l2_normalize_scale_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // opcode, channel_index, scale_word, sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // result
    output logic [5:0]  m_axis_tuser,   // out_channel
    output logic        m_axis_tlast
);
    import cl2n_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0]    chan_cnt_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [CNT_BITS-1:0]    fill_reg;
    logic [CHANNELS_MAX-1:0] scale_vld_reg;
    logic [SAMPLE_BITS-1:0] vec_mem [CHANNELS_MAX];
    logic [15:0]            scale_mem [CHANNELS_MAX];
    logic [SAMPLE_BITS-1:0] vec_rd_reg;
    logic [15:0]            scale_rd_reg;
    logic [CNT_BITS-1:0]    k_reg;
    logic [SUM_BITS-1:0]    rem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [4:0]             step_reg;
    logic [PROD_BITS-1:0]   quo_reg;
    logic [PROD_BITS:0]     drem_reg;
    logic                   neg_reg;
    logic [15:0]            res_reg;
    logic [IDX_BITS-1:0]    oidx_reg;
    logic                   olast_reg;
    logic                   ovld_reg;

    logic                   op;
    logic [IDX_BITS-1:0]    in_idx;
    logic [15:0]            in_scale;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                   acc_in;
    logic [SAMPLE_BITS-1:0] in_mag;
    logic [SUM_BITS-1:0]    sq;
    logic [SUM_BITS:0]      sum_add;
    logic [CNT_BITS-1:0]    eff_cnt;
    logic [CNT_BITS-1:0]    fill_inc;
    logic [IDX_BITS-1:0]    wr_pos;
    logic                   vec_done;
    logic [SUM_BITS:0]      trial;
    logic [PROD_BITS:0]     dsh;
    logic [PROD_BITS:0]     dsub;
    logic [SAMPLE_BITS-1:0] rd_mag;
    logic [CNT_BITS-1:0]    k_inc;
    logic [IDX_BITS-1:0]    rd_addr;

    assign op        = s_axis_tdata[0];
    assign in_idx    = s_axis_tdata[6:1];
    assign in_scale  = s_axis_tdata[22:7];
    assign in_sample = s_axis_tdata[38:23];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc_in    = s_axis_tvalid && s_axis_tready;

    // square of the incoming element and saturating add
    assign in_mag  = in_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_sample)
                                              : SAMPLE_BITS'(in_sample);
    assign sq      = SUM_BITS'(in_mag) * SUM_BITS'(in_mag);
    assign sum_add = {1'b0, sum_reg} + {1'b0, sq};
    assign eff_cnt = (chan_cnt_reg == '0) ? CNT_BITS'(1)
                   : ((chan_cnt_reg > CNT_BITS'(CHANNELS_MAX)) ? CNT_BITS'(CHANNELS_MAX)
                   : chan_cnt_reg);
    assign wr_pos   = (fill_reg >= CNT_BITS'(CHANNELS_MAX)) ? IDX_BITS'(CHANNELS_MAX - 1)
                                                            : fill_reg[IDX_BITS-1:0];
    assign fill_inc = CNT_BITS'({1'b0, wr_pos}) + CNT_BITS'(1);
    assign vec_done = s_axis_tlast || (fill_inc >= eff_cnt);

    // sqrt trial subtract (rem - (root << (b+1)) - (1 << 2b)); the divider step has its own subtract
    assign trial = {1'b0, rem_reg}
                   - ((SUM_BITS+1)'(root_reg) << (step_reg + 5'd1))
                   - ((SUM_BITS+1)'(1) << {step_reg, 1'b0});
    assign dsh   = {drem_reg[PROD_BITS-1:0], quo_reg[PROD_BITS-1]};
    assign dsub  = dsh - (PROD_BITS+1)'(root_reg);
    assign rd_mag = vec_rd_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-vec_rd_reg) : vec_rd_reg;
    assign k_inc  = k_reg + CNT_BITS'(1);

    // read address runs one element ahead while the output stage advances
    assign rd_addr = (state_reg == ST_OUT) ? k_inc[IDX_BITS-1:0] : k_reg[IDX_BITS-1:0];

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (acc_in && op == OP_DATA && vec_done) state_next = ST_SQRT;
            ST_SQRT: if (step_reg == 5'd0) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (step_reg == 5'd0) state_next = ST_OUT;
            ST_OUT:  if (!ovld_reg || m_axis_tready)
                         state_next = (k_inc == fill_reg) ? ST_IDLE : ST_MUL;
            default: state_next = ST_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (acc_in && op == OP_DATA)
            vec_mem[wr_pos] <= in_sample;
        if (acc_in && op == OP_LOAD_SCALE)
            scale_mem[in_idx] <= in_scale;
        vec_rd_reg   <= vec_mem[rd_addr];
        scale_rd_reg <= scale_vld_reg[rd_addr] ? scale_mem[rd_addr] : 16'd0;
    end

    // control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_cnt_reg  <= CNT_BITS'(64);
            sum_reg       <= '0;
            fill_reg      <= '0;
            scale_vld_reg <= '0;
            k_reg         <= '0;
            step_reg      <= '0;
            ovld_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                chan_cnt_reg <= cfg_wr_data;
            if (state_reg == ST_OUT && (!ovld_reg || m_axis_tready))
                ovld_reg <= 1'b1;
            else if (ovld_reg && m_axis_tready)
                ovld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc_in && op == OP_LOAD_SCALE)
                        scale_vld_reg[in_idx] <= 1'b1;
                    if (acc_in && op == OP_DATA)
                    begin
                        sum_reg  <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
                        fill_reg <= fill_inc;
                        if (vec_done)
                        begin
                            rem_reg  <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
                            root_reg <= '0;
                            step_reg <= 5'd18;
                            k_reg    <= '0;
                        end
                    end
                end
                ST_SQRT:
                begin
                    // one root bit per cycle, from bit 18 down
                    if (!trial[SUM_BITS])
                    begin
                        rem_reg  <= trial[SUM_BITS-1:0];
                        root_reg <= root_reg | (ROOT_BITS'(1) << step_reg);
                    end
                    step_reg <= step_reg - 5'd1;
                end
                ST_MUL:
                begin
                    quo_reg  <= PROD_BITS'(rd_mag) * PROD_BITS'(scale_rd_reg);
                    neg_reg  <= vec_rd_reg[SAMPLE_BITS-1];
                    drem_reg <= '0;
                    step_reg <= 5'd31;
                end
                ST_DIV:
                begin
                    if (!dsub[PROD_BITS])
                    begin
                        drem_reg <= dsub;
                        quo_reg  <= {quo_reg[PROD_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dsh;
                        quo_reg  <= {quo_reg[PROD_BITS-2:0], 1'b0};
                    end
                    step_reg <= step_reg - 5'd1;
                end
                ST_OUT:
                begin
                    if (!ovld_reg || m_axis_tready)
                    begin
                        k_reg    <= k_inc;
                        if (k_inc == fill_reg)
                        begin
                            sum_reg  <= '0;
                            fill_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!ovld_reg || m_axis_tready))
        begin
            if (root_reg == '0)
                res_reg <= 16'd0;
            else if (neg_reg)
                res_reg <= (quo_reg > 32'd32768) ? 16'h8000 : 16'(-quo_reg);
            else
                res_reg <= (quo_reg > 32'd32767) ? 16'h7FFF : quo_reg[15:0];
            oidx_reg  <= k_reg[IDX_BITS-1:0];
            olast_reg <= (k_inc == fill_reg);
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = res_reg;
    assign m_axis_tuser  = oidx_reg;
    assign m_axis_tlast  = olast_reg;

    // checks
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovld_reg && !m_axis_tready |=> ovld_reg && $stable(res_reg))
        else $error("result dropped while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_axis_tready)
        else $error("input taken while busy");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_BITS'(CHANNELS_MAX))
        else $error("fill count overrun");
endmodule

[test/cl2n_checker.sv]
// Checker: watches both stream channels, predicts normalized results, compares them.
`timescale 1ns / 1ps
module cl2n_checker
    import cl2n_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [5:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending_count
);
    typedef struct packed {
        logic [15:0] result;
        logic [5:0]  channel;
        logic        last;
    } norm_result_t;

    norm_result_t        expected_q[$];
    logic [6:0]          count_reg;
    logic signed [15:0]  element_buf[CHANNELS_MAX];
    logic [15:0]         scale_buf[CHANNELS_MAX];
    logic [63:0]         sum_sq;
    int                  fill;

    // Floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem, root, b;
        rem = v;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // Scaled, truncated and saturated quotient
    function automatic logic [15:0] scale_element(input logic signed [15:0] x,
                                                  input logic [15:0] sc,
                                                  input logic [63:0] norm);
        logic [63:0] mag, q;
        if (norm == 0)
            return 16'h0;
        mag = (x < 0) ? 64'(-int'(x)) : 64'(x);
        q = (mag * sc) / norm;
        if (x < 0)
        begin
            if (q > 64'd32768)
                q = 64'd32768;
            return 16'(-q);
        end
        if (q > 64'd32767)
            q = 64'd32767;
        return q[15:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic accept_item(input logic [39:0] d, input logic lst);
        logic signed [15:0] x;
        logic [63:0] mag, norm;
        int eff;
        norm_result_t r;
        if (d[0] == OP_LOAD_SCALE)
        begin
            scale_buf[d[6:1]] = d[22:7];
            return;
        end
        x = d[38:23];
        if (fill >= CHANNELS_MAX)
            fill = CHANNELS_MAX - 1;
        element_buf[fill] = x;
        mag = (x < 0) ? 64'(-int'(x)) : 64'(x);
        sum_sq += mag * mag;
        fill++;
        eff = (count_reg == 0) ? 1 : (count_reg > CHANNELS_MAX ? CHANNELS_MAX : count_reg);
        if (!lst && fill < eff)
            return;
        norm = floor_sqrt(sum_sq);
        for (int k = 0; k < fill; k++)
        begin
            r.result = scale_element(element_buf[k], scale_buf[k], norm);
            r.channel = 6'(k);
            r.last = (k + 1 == fill);
            expected_q.push_back(r);
        end
        sum_sq = 0;
        fill = 0;
    endtask

    // Track configuration, input and output transfers
    always @(posedge clk or negedge rst_n)
    begin
        norm_result_t e;
        if (!rst_n)
        begin
            count_reg = 7'd64;
            sum_sq = 0;
            fill = 0;
            fail_count = 0;
            for (int i = 0; i < CHANNELS_MAX; i++)
                scale_buf[i] = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
                count_reg = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                accept_item(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
                else
                begin
                    e = expected_q.pop_front();
                    if (m_axis_tdata !== e.result)
                        report_mismatch($sformatf("ch %0d result %h, want %h",
                                        e.channel, m_axis_tdata, e.result));
                    if (m_axis_tuser !== e.channel)
                        report_mismatch($sformatf("channel %0d, want %0d",
                                        m_axis_tuser, e.channel));
                    if (m_axis_tlast !== e.last)
                        report_mismatch($sformatf("ch %0d last %b, want %b",
                                        e.channel, m_axis_tlast, e.last));
                end
            end
        end
        pending_count = expected_q.size();
    end
endmodule

[test/tb_top.sv]
// Testbench top: drives stimulus and idling into the normalize unit and gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import cl2n_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    int          cycle_count;

    channel_l2_normalize_scale_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    cl2n_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off_cycles <= hold_off_cycles - 1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // One input transfer, with random idle cycles before it
    task automatic send_item(input logic op, input logic [5:0] idx, input logic [15:0] sc,
                             input logic [15:0] smp, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, smp, sc, idx, op};
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_data(input logic [15:0] smp, input logic lst);
        send_item(OP_DATA, 6'($urandom), 16'($urandom), smp, lst);
    endtask

    task automatic load_scale(input logic [5:0] idx, input logic [15:0] sc);
        send_item(OP_LOAD_SCALE, idx, sc, 16'($urandom), 1'($urandom));
    endtask

    // Stop sending, wait for all results, then allow for any work still in flight
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    task automatic set_count(input logic [6:0] n);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(3))
            0: return 16'($urandom_range(255));
            1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // A vector of len elements; early_last marks its end with tlast
    task automatic send_vector(input int len, input bit early_last);
        for (int i = 0; i < len; i++)
            send_data(rand_sample(), early_last && (i == len - 1));
    endtask

    initial
    begin
        int cnt;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 7'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero scales at reset, then extremes
        send_data(16'h7FFF, 1'b1);
        load_scale(6'd0, 16'hFFFF);
        load_scale(6'd1, 16'h0100);
        load_scale(6'd2, 16'h0001);
        send_data(16'h0000, 1'b0);
        send_data(16'h0000, 1'b1);           // zero norm
        send_data(16'h8000, 1'b0);
        send_data(16'h0001, 1'b0);
        send_data(16'h7FFF, 1'b1);
        send_data(16'h0001, 1'b1);           // single element saturates high
        send_data(16'hFFFF, 1'b1);           // saturates low
        send_data(16'h8000, 1'b0);
        load_scale(6'd63, 16'hAAAA);         // load mid-vector
        send_data(16'h0100, 1'b1);
        set_count(7'd1);                     // each element ends a vector
        send_data(16'h1234, 1'b0);
        send_data(16'hF000, 1'b0);
        set_count(7'd0);                     // treated as one
        send_data(16'h4321, 1'b0);
        set_count(7'd127);                   // clamped to 64
        send_data(16'h0200, 1'b1);

        // Fill the scale table
        for (int i = 0; i < CHANNELS_MAX; i++)
            load_scale(6'(i), 16'($urandom_range(0, 1023)));

        // Full 64-element vector without tlast, receiver held off while
        // the next vector is offered and waits at the input
        set_count(7'd64);
        hold_off_cycles = 400;
        send_vector(64, 1'b0);
        send_vector(8, 1'b1);

        // Random phases over several channel counts and idling mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            cnt = (ph == 7) ? 2 : $urandom_range(1, 8);
            set_count(7'(cnt));
            for (int v = 0; v < 4; v++)
            begin
                if ($urandom_range(9) < 2)
                    load_scale(6'($urandom), 16'($urandom));
                if ($urandom_range(3) == 0)
                    send_vector($urandom_range(1, cnt), 1'b1);
                else
                    send_vector(cnt, 1'b0);
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
